[hdl/ppmfd_pkg.sv]
// Shared constants and types for the PPM frame decoder.
package ppmfd_pkg;

  // Number of channel slots in one frame (1 to 8, so each slot has its own CHAN_W-bit channel number).
  localparam int CHANNELS = 8;

  localparam int PHASE_W = 4;
  localparam int FAST_W  = 16;
  localparam int SLOW_W  = 8;
  localparam int CHAN_W  = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Phase value of the last channel slot.
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(CHANNELS);
  localparam logic [PHASE_W-1:0] PHASE_HUNT = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SYNC_GAP_MIN = 2'd0,
    REG_SYNC_GAP_MAX = 2'd1,
    REG_PULSE_MIN    = 2'd2,
    REG_PULSE_MAX    = 2'd3
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [SLOW_W-1:0] SYNC_GAP_MIN_RST = 8'd109;
  localparam logic [SLOW_W-1:0] SYNC_GAP_MAX_RST = 8'd255;
  localparam logic [FAST_W-1:0] PULSE_MIN_RST    = 16'd14400;
  localparam logic [FAST_W-1:0] PULSE_MAX_RST    = 16'd35200;

  // Per-edge status flags, pulse_stored in the lowest bit.
  typedef struct packed {
    logic frame_error;
    logic frame_complete;
    logic sync_seen;
    logic pulse_stored;
  } ppm_flags_t;

endpackage

[hdl/ppm_frame_decoder_core.sv]
// PPM frame decoder: timestamps of capture edges in, per-edge decode status out.
//
// The decoder takes one capture edge per request on the slave stream and returns
// exactly one result per edge on the master stream, in order. The width and the
// sync/data decision are formed by compare logic directly from the incoming
// timestamps and the decoder state, and land in a single output register on
// acceptance. The output register frees itself in the same cycle it is taken, so
// with the master side always ready a new edge is accepted every cycle; s_tready
// drops only while a result waits. While hunting, an edge is a sync when the
// wrapping slow-time gap since the sync mark, set by the previous hunting edge
// or by the edge that ended the last frame, lies strictly between sync_gap_min
// and sync_gap_max. After a sync, each pulse width inside [pulse_min, pulse_max]
// is reported as a stored channel; the last channel raises frame_complete and a
// width outside the bounds raises frame_error, and both send the decoder back to
// hunting. Configuration registers are written through cfg_we/cfg_addr/cfg_data
// and must only be changed while no edge is in flight.
module ppm_frame_decoder_core (
  input  logic clk,
  input  logic rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [ppmfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Capture edge stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata: capture_time [15:0], slow_time [23:16].
  input  logic [ppmfd_pkg::IN_DATA_W-1:0]       s_tdata,
  // Decode result stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: channel [2:0], pulse_width [18:3], zero [23:19].
  output logic [ppmfd_pkg::OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: pulse_stored [0], sync_seen [1], frame_complete [2], frame_error [3].
  output ppmfd_pkg::ppm_flags_t                 m_tuser
);
  import ppmfd_pkg::*;

  // Configuration registers.
  logic [SLOW_W-1:0] sync_gap_min;
  logic [SLOW_W-1:0] sync_gap_max;
  logic [FAST_W-1:0] pulse_min;
  logic [FAST_W-1:0] pulse_max;

  // Decoder state.
  logic [FAST_W-1:0]  prev_capture;
  logic [PHASE_W-1:0] phase;
  logic [SLOW_W-1:0]  sync_mark;
  logic [PHASE_W-1:0] phase_next;
  logic [SLOW_W-1:0]  sync_mark_next;

  // Output register contents.
  logic [CHAN_W-1:0]  out_channel;
  logic [FAST_W-1:0]  out_width;

  logic [FAST_W-1:0]  now_time;
  logic [SLOW_W-1:0]  slow_now;
  logic [FAST_W-1:0]  width;
  logic [SLOW_W-1:0]  gap;
  logic [PHASE_W-1:0] slot;
  logic [CHAN_W-1:0]  chan;
  ppm_flags_t         flags;
  logic               accept;

  assign now_time = s_tdata[FAST_W-1:0];
  assign slow_now = s_tdata[FAST_W +: SLOW_W];

  // The output register can load whenever it is empty or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign width = now_time - prev_capture;
  assign gap   = slow_now - sync_mark;
  assign slot  = phase - PHASE_W'(1);

  // Sync hunt, range check and channel advance for the current edge.
  always_comb begin
    phase_next     = phase;
    sync_mark_next = sync_mark;
    flags          = '0;
    chan           = '0;
    if (phase == PHASE_HUNT) begin
      // Every hunting edge becomes the new reference for the gap.
      sync_mark_next = slow_now;
      if (gap > sync_gap_min && gap < sync_gap_max) begin
        phase_next      = PHASE_W'(1);
        flags.sync_seen = 1'b1;
      end
    end else if (width > pulse_max || width < pulse_min) begin
      flags.frame_error = 1'b1;
      phase_next        = PHASE_HUNT;
      sync_mark_next    = slow_now;
    end else begin
      flags.pulse_stored = 1'b1;
      chan               = slot[CHAN_W-1:0];
      if (phase >= LAST_PHASE) begin
        // Last slot of the frame: report it and go back to hunting.
        flags.frame_complete = 1'b1;
        phase_next           = PHASE_HUNT;
        sync_mark_next       = slow_now;
      end else begin
        phase_next = phase + PHASE_W'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_gap_min <= SYNC_GAP_MIN_RST;
      sync_gap_max <= SYNC_GAP_MAX_RST;
      pulse_min    <= PULSE_MIN_RST;
      pulse_max    <= PULSE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SYNC_GAP_MIN: sync_gap_min <= cfg_data[SLOW_W-1:0];
        REG_SYNC_GAP_MAX: sync_gap_max <= cfg_data[SLOW_W-1:0];
        REG_PULSE_MIN:    pulse_min    <= cfg_data;
        REG_PULSE_MAX:    pulse_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state, updated once per accepted edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_capture <= '0;
      phase        <= PHASE_HUNT;
      sync_mark    <= '0;
    end else if (accept) begin
      prev_capture <= now_time;
      phase        <= phase_next;
      sync_mark    <= sync_mark_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_channel <= chan;
      out_width   <= width;
      m_tuser     <= flags;
    end
  end

  assign m_tdata = {(OUT_DATA_W - CHAN_W - FAST_W)'(0), out_width, out_channel};

endmodule

[bench/ppm_frame_decoder_core_tb.sv]
// Self-checking testbench for the PPM frame decoder core.
`timescale 1ns / 1ps

module ppm_frame_decoder_core_tb;
  import ppmfd_pkg::*;

  // One decode result as the block reports it for a single capture edge.
  typedef struct packed {
    logic        stored;
    logic [2:0]  chan;
    logic [15:0] width;
    logic        sync;
    logic        done;
    logic        err;
  } decode_result_t;

  // Frame decoder model plus the queue of results still owed by the block.
  // Every accepted capture edge is decoded here the moment the request is
  // taken, and the result lands at the back of the queue; results coming out
  // of the block are matched against the front in order.
  class ppm_scoreboard;
    logic [7:0]  gap_min;
    logic [7:0]  gap_max;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [15:0] prev;
    logic [3:0]  phase;
    logic [7:0]  mark;
    decode_result_t pending[$];
    int unsigned errors;

    function new();
      gap_min   = SYNC_GAP_MIN_RST;
      gap_max   = SYNC_GAP_MAX_RST;
      pulse_min = PULSE_MIN_RST;
      pulse_max = PULSE_MAX_RST;
      prev      = '0;
      phase     = PHASE_HUNT;
      mark      = '0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] value);
      case (idx)
        REG_SYNC_GAP_MIN: gap_min = value[7:0];
        REG_SYNC_GAP_MAX: gap_max = value[7:0];
        REG_PULSE_MIN:    pulse_min = value;
        REG_PULSE_MAX:    pulse_max = value;
        default: ;
      endcase
    endfunction

    function void note_edge(logic [15:0] cap, logic [7:0] slow);
      decode_result_t r;
      logic [7:0] gap;
      logic [3:0] slot;
      r = '0;
      // The width is measured on every edge, hunting or not.
      r.width = cap - prev;
      prev = cap;
      if (phase == PHASE_HUNT) begin
        // The mark follows every hunting edge, accepted as sync or not.
        gap = slow - mark;
        mark = slow;
        if (gap > gap_min && gap < gap_max) begin
          phase = 4'd1;
          r.sync = 1'b1;
        end
      end else if (r.width > pulse_max || r.width < pulse_min) begin
        r.err = 1'b1;
        phase = PHASE_HUNT;
        mark = slow;
      end else begin
        slot = phase - 4'd1;
        r.stored = 1'b1;
        r.chan = slot[2:0];
        if (phase >= LAST_PHASE) begin
          r.done = 1'b1;
          phase = PHASE_HUNT;
          mark = slow;
        end else begin
          phase = phase + 4'd1;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data, ppm_flags_t flags);
      decode_result_t e;
      if (pending.size() == 0) begin
        $error("result: expected none, got data %h flags %h", data, flags);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("pulse_stored", e.stored, flags.pulse_stored);
      check_field("channel", e.chan, data[2:0]);
      check_field("pulse_width", e.width, data[18:3]);
      check_field("tdata_pad", 0, data[23:19]);
      check_field("sync_seen", e.sync, flags.sync_seen);
      check_field("frame_complete", e.done, flags.frame_complete);
      check_field("frame_error", e.err, flags.frame_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // s_tdata: capture_time [15:0], slow_time [23:16].
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // m_tdata: channel [2:0], pulse_width [18:3], zero [23:19].
  logic [OUT_DATA_W-1:0] m_tdata;
  // m_tuser: pulse_stored [0], sync_seen [1], frame_complete [2], frame_error [3].
  ppm_flags_t m_tuser;

  ppm_scoreboard sb = new();
  int unsigned src_idle_pct = 15;
  int unsigned snk_idle_pct = 70;
  int unsigned edges_sent = 0;

  ppm_frame_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Result side: ready is redrawn every cycle, and each taken result is
  // checked against the oldest outstanding prediction. Signals are sampled
  // right after the edge, so they still hold the values the block saw there.
  initial begin
    forever begin
      m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Offers one capture edge after a random number of idle cycles and returns
  // at the edge where the request is taken. Valid is left high so that the
  // next request can follow back to back.
  task automatic send_edge(input logic [15:0] cap, input logic [7:0] slow);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {slow, cap};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_edge(cap, slow);
    edges_sent++;
  endtask

  // An edge one pulse width after the previous one.
  task automatic send_width(input logic [15:0] width, input logic [7:0] slow);
    send_edge(sb.prev + width, slow);
  endtask

  // An edge whose slow time lies the given gap after the current sync mark.
  task automatic send_gap(input logic [7:0] gap);
    send_edge(16'($urandom), sb.mark + gap);
  endtask

  // Waits at clock edges until every predicted result has come back.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // A slow-time gap that is usually a valid sync under the current bounds.
  function automatic logic [7:0] pick_gap();
    if ($urandom_range(99, 0) < 85 && sb.gap_max > sb.gap_min + 1)
      return 8'($urandom_range(sb.gap_max - 1, sb.gap_min + 1));
    return 8'($urandom_range(255, 0));
  endfunction

  // A pulse width inside the data bounds, hitting each bound now and then.
  function automatic logic [15:0] good_width();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (sb.pulse_min > sb.pulse_max) return 16'($urandom);
    if (r < 10) return sb.pulse_min;
    if (r < 20) return sb.pulse_max;
    return 16'($urandom_range(sb.pulse_max, sb.pulse_min));
  endfunction

  // A pulse width outside the data bounds, often just one tick outside.
  // With the bounds wide open no such width exists and a good one is used.
  function automatic logic [15:0] bad_width();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (sb.pulse_min > 0 && (sb.pulse_max == 16'hFFFF || $urandom_range(1, 0)))
      return (r < 20) ? sb.pulse_min - 16'd1
                      : 16'($urandom_range(sb.pulse_min - 1, 0));
    if (sb.pulse_max != 16'hFFFF)
      return (r < 20) ? sb.pulse_max + 16'd1
                      : 16'($urandom_range(65535, sb.pulse_max + 1));
    return good_width();
  endfunction

  // A sync edge followed by a full set of channel pulses. With abort set, one
  // of the pulses is out of range, which cuts the frame short there.
  task automatic send_frame(input bit abort);
    int unsigned bad_at;
    bad_at = abort ? $urandom_range(CHANNELS - 1, 0) : CHANNELS;
    send_gap(pick_gap());
    for (int i = 0; i < CHANNELS; i++) begin
      if (i == bad_at) begin
        send_width(bad_width(), 8'($urandom));
        break;
      end
      send_width(good_width(), 8'($urandom));
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Lets the block drain, loads a new set of bounds and then runs random
  // traffic: mostly well-formed frames, some aborted ones and some noise.
  // The 8-bit registers get random upper bits, which the block must ignore.
  task automatic run_phase(input logic [7:0] gmin, input logic [7:0] gmax,
                           input logic [15:0] pmin, input logic [15:0] pmax,
                           input int unsigned count);
    int unsigned target;
    int unsigned r;
    drain();
    repeat (3) @(posedge clk);
    write_reg(REG_SYNC_GAP_MIN, {8'($urandom), gmin});
    write_reg(REG_SYNC_GAP_MAX, {8'($urandom), gmax});
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_PULSE_MAX, pmax);
    cfg_we <= 1'b0;
    @(posedge clk);
    target = edges_sent + count;
    while (edges_sent < target) begin
      r = $urandom_range(99, 0);
      if (r < 70) send_frame(1'b0);
      else if (r < 88) send_frame(1'b1);
      else send_edge(16'($urandom), 8'($urandom));
    end
    // Drop valid in the step of the last handshake so nothing is repeated.
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset bounds (gap 109..255, width 14400..35200).
    // Zero and all-ones timestamps; gaps of exactly the lower bound and of
    // zero are no sync, one tick more is.
    send_edge(16'h0000, 8'd0);
    send_edge(16'hFFFF, 8'd109);
    send_gap(8'd110);
    // A complete frame with both width bounds; the last slot restarts the hunt.
    send_width(16'd14400, 8'd3);
    send_width(16'd35200, 8'd0);
    for (int i = 0; i < CHANNELS - 3; i++) send_width(16'd20000, 8'd77);
    send_width(16'd30000, 8'd255);
    // The mark moved to the completing edge; a gap equal to the upper bound
    // fails, and since the mark follows that edge too, one below it succeeds.
    send_gap(8'd255);
    send_gap(8'd254);
    // One tick under the lower width bound aborts the frame.
    send_width(16'd14399, 8'd40);
    send_gap(8'd200);
    // One tick over the upper width bound aborts as well.
    send_width(16'd35201, 8'd11);
    send_gap(8'd128);
    send_width(16'd35200, 8'd90);
    send_width(16'd65535, 8'd200);
    s_tvalid <= 1'b0;

    run_phase(8'd109, 8'd255, 16'd14400, 16'd35200, 150);
    // Bounds wide open: every sync gap but the extremes and every width pass.
    run_phase(8'd0, 8'd255, 16'd0, 16'hFFFF, 60);

    src_idle_pct = 70;
    snk_idle_pct = 15;
    // Crossed sync bounds: the decoder never leaves the hunt.
    run_phase(8'd200, 8'd100, 16'd40000, 16'd1000, 30);
    // Crossed width bounds: every pulse after a sync is an error.
    run_phase(8'd20, 8'd60, 16'd5000, 16'd4000, 30);
    // Tight bounds: only a gap of two syncs, and widths are a narrow window.
    run_phase(8'd1, 8'd3, 16'd100, 16'd200, 80);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(8'd50, 8'd200, 16'd1000, 16'd60000, 150);

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
